### sv/last_note_priority_key_stack_defines.svh
// Assertion macros for the last-note priority key stack.
// Included by the modules that check their own control logic; no other dependency.
// In synthesis the macros expand to nothing.
`ifndef LAST_NOTE_PRIORITY_KEY_STACK_DEFINES_SVH
`define LAST_NOTE_PRIORITY_KEY_STACK_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define LNPKS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("key stack check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LNPKS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("key stack check failed");

`else

`define LNPKS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LNPKS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### sv/lnpks_pkg.sv
// Shared types and constants for the last-note priority key stack.
// No dependencies; used by lnpks_cell and last_note_priority_key_stack.
package lnpks_pkg;

  localparam int KEY_W          = 7;
  localparam int CNT_W          = 8;
  localparam int NOTE_RANGE_DEF = 128;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ENV_NONE    = 2'd0,
    ENV_ATTACK  = 2'd1,
    ENV_RELEASE = 2'd2
  } env_cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_e;

  // Wave that travels up the row of cells, one cell per cycle.
  typedef struct packed {
    logic tok;   // the wave is at the receiving cell this cycle
    logic fnd;   // the removed key was found below the receiving cell
    key_t last;  // newest surviving key seen so far
  } link_t;

  // Signals broadcast from the controller to every cell.
  typedef struct packed {
    key_t key;     // key of the event being processed
    cnt_t depth;   // stack depth before the event
    logic wr_en;   // push the key this cycle
    cnt_t wr_idx;  // stack position of the push
  } bcast_t;

endpackage

### sv/lnpks_cell.sv
// One stack entry of the key stack plus its stage of the removal wave.
// Depends on lnpks_pkg.
module lnpks_cell #(
  parameter int IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lnpks_pkg::link_t  link_i,
  output lnpks_pkg::link_t  link_o,
  input  lnpks_pkg::bcast_t bc_i,
  input  lnpks_pkg::key_t   up_key_i,
  output lnpks_pkg::key_t   key_o
);
  import lnpks_pkg::*;

  localparam cnt_t MY_IDX = CNT_W'(IDX);

  key_t key_q, key_d;
  logic tok_q;
  logic fnd_q, fnd_d;
  key_t last_q, last_d;
  logic valid;
  logic hit;

  always_comb begin
    valid  = (MY_IDX < bc_i.depth);
    hit    = link_i.tok && valid && (key_q == bc_i.key);
    fnd_d  = link_i.fnd | hit;
    last_d = (valid && !hit) ? key_q : link_i.last;
    if (link_i.tok && fnd_d) begin
      // Close the gap: take the entry above before it moves itself.
      key_d = up_key_i;
    end else if (bc_i.wr_en && (bc_i.wr_idx == MY_IDX)) begin
      key_d = bc_i.key;
    end else begin
      key_d = key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= link_i.tok;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    fnd_q  <= fnd_d;
    last_q <= last_d;
  end

  assign link_o = '{tok: tok_q, fnd: fnd_q, last: last_q};
  assign key_o  = key_q;

endmodule

### sv/last_note_priority_key_stack.sv
// Last-note priority key stack: a monophonic key assigner over a row of stack cells.
// An event is accepted while idle, and the result strobe follows once the removal wave
// has passed the whole cell row; no new event is accepted (busy) until the wave is out.
// The result is shown for one cycle only; the receiver cannot stall the block.
// Reset clears count, sounding note, level and gate; stack entries stay unwritten.
// Depends on lnpks_pkg, lnpks_cell and last_note_priority_key_stack_defines.svh.
`include "last_note_priority_key_stack_defines.svh"

module last_note_priority_key_stack #(
  parameter int NOTE_RANGE = lnpks_pkg::NOTE_RANGE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 op_i,
  input  lnpks_pkg::key_t      note_i,
  input  logic [6:0]           strike_i,
  output logic                 result_valid_o,
  output logic                 gate_o,
  output logic                 note_valid_o,
  output lnpks_pkg::key_t      current_note_o,
  output logic [6:0]           level_o,
  output logic [1:0]           envelope_command_o,
  output lnpks_pkg::cnt_t      held_count_o
);
  import lnpks_pkg::*;

  // The stack depth fits the count width if NOTE_RANGE is at most 128; the block does not check this.
  localparam cnt_t RANGE_CNT = CNT_W'(NOTE_RANGE);

  // Control state.
  state_e   state_q, state_d;
  logic     head_tok_q;
  logic     strobe_q;

  // Architectural state that is visible on the result ports.
  cnt_t     depth_q, depth_d;
  key_t     snote_q, snote_d;
  logic     sval_q, sval_d;
  logic [6:0] level_q, level_d;
  logic     gate_q, gate_d;
  env_cmd_e env_q, env_d;

  // The event being worked on, captured on the accepting beat.
  key_t     key_q;
  logic [6:0] vel_q;
  logic     press_q;
  logic     in_range_q;

  logic     launch;
  logic     finish;
  cnt_t     depth_rm;
  logic     wr_en;
  bcast_t   bc;

  // The removal wave: link[0] is launched by the controller, link[NOTE_RANGE]
  // comes out of the top cell's register once the wave has passed the whole row.
  link_t    link [NOTE_RANGE+1];
  key_t     keys [NOTE_RANGE];

  // Next state: a walk starts on an accepted beat and ends when the wave
  // leaves the top cell.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (link[NOTE_RANGE].tok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    busy   = 1'b0;
    launch = 1'b0;
    finish = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        launch = start;
      end
      ST_WALK: begin
        busy   = 1'b1;
        finish = link[NOTE_RANGE].tok;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // When the wave is out, the key has been removed if it was held, and the
  // wave carries the newest surviving key. The press pushes on top, and a
  // release of the sounding note falls back to that key or closes the gate.
  always_comb begin
    depth_rm = depth_q - CNT_W'(link[NOTE_RANGE].fnd);
    depth_d  = depth_q;
    snote_d  = snote_q;
    sval_d   = sval_q;
    level_d  = level_q;
    gate_d   = gate_q;
    env_d    = env_q;
    wr_en    = 1'b0;
    if (finish) begin
      env_d = ENV_NONE;
      if (in_range_q) begin
        depth_d = depth_rm;
        if (press_q) begin
          if (depth_rm < RANGE_CNT) begin
            wr_en   = 1'b1;
            depth_d = depth_rm + 1'b1;
          end
          snote_d = key_q;
          sval_d  = 1'b1;
          level_d = vel_q;
          gate_d  = 1'b1;
          env_d   = ENV_ATTACK;
        end else if (sval_q && (key_q == snote_q)) begin
          if (depth_rm != '0) begin
            snote_d = link[NOTE_RANGE].last;
            env_d   = ENV_ATTACK;
          end else begin
            gate_d = 1'b0;
            env_d  = ENV_RELEASE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_tok_q <= 1'b0;
      strobe_q   <= 1'b0;
      depth_q    <= '0;
      snote_q    <= '0;
      sval_q     <= 1'b0;
      level_q    <= '0;
      gate_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_tok_q <= launch;
      strobe_q   <= finish;
      depth_q    <= depth_d;
      snote_q    <= snote_d;
      sval_q     <= sval_d;
      level_q    <= level_d;
      gate_q     <= gate_d;
    end
  end

  // Event payload and the envelope command need no reset.
  always_ff @(posedge clk_i) begin
    env_q <= env_d;
    if (launch) begin
      key_q      <= note_i;
      vel_q      <= strike_i;
      press_q    <= !op_i && (strike_i != '0);
      in_range_q <= ({1'b0, note_i} < RANGE_CNT);
    end
  end

  assign bc = '{key: key_q, depth: depth_q, wr_en: wr_en, wr_idx: depth_rm};

  assign link[0] = '{tok: head_tok_q, fnd: 1'b0, last: '0};

  // The row of stack cells, bottom of the stack at cell 0.
  for (genvar g = 0; g < NOTE_RANGE; g++) begin : g_cell
    key_t up_key;
    if (g == NOTE_RANGE - 1) begin : g_top
      assign up_key = keys[g];
    end else begin : g_mid
      assign up_key = keys[g+1];
    end
    lnpks_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .link_i   (link[g]),
      .link_o   (link[g+1]),
      .bc_i     (bc),
      .up_key_i (up_key),
      .key_o    (keys[g])
    );
  end

  assign result_valid_o     = strobe_q;
  assign gate_o             = gate_q;
  assign note_valid_o       = sval_q;
  assign current_note_o     = snote_q;
  assign level_o            = level_q;
  assign envelope_command_o = 2'(env_q);
  assign held_count_o       = depth_q;

  // A result beat is only produced once the walk is over.
  `LNPKS_ASSERT_IMP(a_strobe_idle, clk_i, rst_ni, strobe_q, state_q == ST_IDLE)
  // The wave only leaves the row while a walk is in progress.
  `LNPKS_ASSERT_IMP(a_tail_in_walk, clk_i, rst_ni, link[NOTE_RANGE].tok, state_q == ST_WALK)
  // The stack never holds more keys than there are notes.
  `LNPKS_ASSERT_IMP(a_depth_bound, clk_i, rst_ni, 1'b1, depth_q <= RANGE_CNT)
  // An open gate implies that a note has been assigned.
  `LNPKS_ASSERT_IMP(a_gate_valid, clk_i, rst_ni, gate_q, sval_q)
  // An accepted beat launches the wave into the bottom cell.
  `LNPKS_ASSERT_NXT(a_launch, clk_i, rst_ni, start && !busy, head_tok_q && busy)

endmodule

### tb/last_note_priority_key_stack_tb.sv
// Self-checking testbench for the last-note priority key stack.
// Depends on lnpks_pkg and the last_note_priority_key_stack RTL; reads no files.
// A built-in voice model predicts every result beat and checks it field by field.
module last_note_priority_key_stack_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lnpks_pkg::*;

  // The block is built with its default note range, so every 7-bit note is in range.
  localparam int KEY_SPAN = NOTE_RANGE_DEF;
  // Walk length of the block, used to size the drain wait at the end.
  localparam int LATENCY = KEY_SPAN + 2;
  localparam int ITEM_TARGET = 1600;
  // The worst case is about 1600 beats, each with a full walk and the longest sender gap;
  // the limit leaves several times that.
  localparam int CYCLE_LIMIT = 4_000_000;

  localparam logic OP_NOTE_ON  = 1'b0;
  localparam logic OP_NOTE_OFF = 1'b1;

  // One key event as it is driven onto the command ports.
  typedef struct packed {
    logic       op;
    key_t       key;
    logic [6:0] strike;
  } key_event_t;

  // One voice result as the block reports it after an event.
  typedef struct packed {
    logic       gate;
    logic       valid;
    key_t       note;
    logic [6:0] level;
    env_cmd_e   cmd;
    cnt_t       count;
  } voice_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       start    = 1'b0;
  logic       op_i     = 1'b0;
  key_t       note_i   = '0;
  logic [6:0] strike_i = '0;

  logic       busy;
  logic       result_valid_o;
  logic       gate_o;
  logic       note_valid_o;
  key_t       current_note_o;
  logic [6:0] level_o;
  logic [1:0] envelope_command_o;
  cnt_t       held_count_o;

  last_note_priority_key_stack dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .op_i               (op_i),
    .note_i             (note_i),
    .strike_i           (strike_i),
    .result_valid_o     (result_valid_o),
    .gate_o             (gate_o),
    .note_valid_o       (note_valid_o),
    .current_note_o     (current_note_o),
    .level_o            (level_o),
    .envelope_command_o (envelope_command_o),
    .held_count_o       (held_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Events still to be driven, and voice results still to arrive, oldest first.
  key_event_t key_events[$];
  voice_t     voice_due[$];

  // State of the voice model: held keys with the oldest at index 0 and the newest on top.
  key_t       held_stack[$];
  key_t       sounding_key = '0;
  logic       sounding_set = 1'b0;
  logic [6:0] stored_strike = '0;
  logic       gate_held = 1'b0;

  int fail_count    = 0;
  int beats_played  = 0;
  int results_seen  = 0;
  int attack_count  = 0;
  int release_count = 0;
  int quiet_count   = 0;
  int peak_held     = 0;
  int cycles        = 0;

  // Applies one key event to the voice model and returns the result it should produce.
  function automatic voice_t play_event(logic op, key_t key, logic [6:0] strike);
    voice_t   res;
    env_cmd_e cmd;
    cmd = ENV_NONE;
    if (int'(key) < KEY_SPAN) begin
      // A key is never held twice: drop any earlier entry before pushing or releasing.
      for (int i = 0; i < held_stack.size(); i++) begin
        if (held_stack[i] == key) begin
          held_stack.delete(i);
          break;
        end
      end
      if (op == OP_NOTE_ON && strike != '0) begin
        if (held_stack.size() < KEY_SPAN) held_stack.push_back(key);
        sounding_key  = key;
        sounding_set  = 1'b1;
        stored_strike = strike;
        gate_held     = 1'b1;
        cmd           = ENV_ATTACK;
      end else if (sounding_set && key == sounding_key) begin
        // Releasing the sounding key falls back to the newest key still down,
        // or closes the gate when none is left. A repeat release of an already
        // released sounding key starts release once more.
        if (held_stack.size() != 0) begin
          sounding_key = held_stack[$];
          cmd          = ENV_ATTACK;
        end else begin
          gate_held = 1'b0;
          cmd       = ENV_RELEASE;
        end
      end
    end
    res.gate  = gate_held;
    res.valid = sounding_set;
    res.note  = sounding_key;
    res.level = stored_strike;
    res.cmd   = cmd;
    res.count = cnt_t'(held_stack.size());
    if (held_stack.size() > peak_held) peak_held = held_stack.size();
    case (cmd)
      ENV_ATTACK: begin
        attack_count++;
      end
      ENV_RELEASE: begin
        release_count++;
      end
      default: begin
        quiet_count++;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endfunction

  // Monitor and predictor. A result is checked before the beat on the same edge is
  // predicted, so a strobe that coincides with the next acceptance meets the older
  // expectation.
  logic beat_taken = 1'b0;

  always @(posedge clk_i) begin
    voice_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycles, voice_due.size());
      $display("FAILURE");
      $finish;
    end else if (!rst_ni) begin
      beat_taken <= 1'b0;
    end else begin
      if (result_valid_o) begin
        if (voice_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual note %0d", $time,
                   current_note_o);
          fail_count++;
        end else begin
          want = voice_due.pop_front();
          results_seen++;
          check_field("gate", want.gate, gate_o);
          check_field("note_valid", want.valid, note_valid_o);
          check_field("current_note", want.note, current_note_o);
          check_field("level", want.level, level_o);
          check_field("envelope_command", want.cmd, envelope_command_o);
          check_field("held_count", want.count, held_count_o);
        end
      end
      beat_taken <= start && !busy;
      if (start && !busy) begin
        voice_due.push_back(play_event(op_i, note_i, strike_i));
        beats_played++;
      end
    end
  end

  // Sender gaps: mostly none or short, a few long enough to span whole walks,
  // and now and then a calm stretch of back-to-back beats.
  int calm_left = 0;
  int gap_left  = 0;

  function automatic int draw_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  // Driver. Start stays high from one beat to the next when no gap follows, so it
  // gets a single assignment per falling edge; it may rise while the block is busy.
  always @(negedge clk_i) begin
    key_event_t ev;
    if (rst_ni && !(start && !beat_taken)) begin
      if (start) gap_left = draw_gap();
      if (gap_left == 0 && key_events.size() != 0) begin
        ev = key_events.pop_front();
        op_i     <= ev.op;
        note_i   <= ev.key;
        strike_i <= ev.strike;
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // Stimulus bookkeeping: which keys the generated sequence holds down, and which
  // key was pressed last, so that releases can aim at the sounding note.
  bit gen_down[KEY_SPAN];
  int gen_held = 0;
  int gen_last = 0;

  task automatic queue_event(input logic op, input int key, input int strike);
    key_event_t ev;
    key_t       slot;
    slot      = key_t'(key);
    ev.op     = op;
    ev.key    = slot;
    ev.strike = strike[6:0];
    key_events.push_back(ev);
    if (op == OP_NOTE_ON && strike[6:0] != '0) begin
      if (!gen_down[slot]) gen_held++;
      gen_down[slot] = 1'b1;
      gen_last = key;
    end else begin
      if (gen_down[slot]) gen_held--;
      gen_down[slot] = 1'b0;
    end
  endtask

  // Returns some key that is down, starting the search at a random note.
  function automatic int pick_held();
    int k;
    k = $urandom_range(0, KEY_SPAN - 1);
    for (int n = 0; n < KEY_SPAN; n++) begin
      if (gen_down[key_t'((k + n) % KEY_SPAN)]) return (k + n) % KEY_SPAN;
    end
    return k;
  endfunction

  // A release comes either as a note off with any velocity or as a zero-velocity note on.
  task automatic queue_release(input int key);
    if ($urandom_range(0, 1)) queue_event(OP_NOTE_OFF, key, $urandom_range(0, 127));
    else queue_event(OP_NOTE_ON, key, 0);
  endtask

  initial begin
    int r;
    int k;
    int base;
    int len;

    // Directed part: releases before any note, the note and velocity extremes,
    // a repeated press, fallback to the newest held key, and release of keys
    // that are not held, including the sounding one a second time.
    queue_event(OP_NOTE_OFF, 60, 0);
    queue_event(OP_NOTE_ON, 61, 0);
    queue_event(OP_NOTE_OFF, 62, 127);
    queue_event(OP_NOTE_ON, 0, 127);
    queue_event(OP_NOTE_ON, 127, 1);
    queue_event(OP_NOTE_ON, 64, 100);
    queue_event(OP_NOTE_ON, 0, 50);
    queue_event(OP_NOTE_OFF, 127, 85);
    queue_event(OP_NOTE_OFF, 0, 0);
    queue_event(OP_NOTE_ON, 64, 0);
    queue_event(OP_NOTE_OFF, 64, 42);
    queue_event(OP_NOTE_OFF, 5, 127);
    queue_event(OP_NOTE_ON, 127, 127);
    queue_event(OP_NOTE_ON, 85, 42);
    queue_event(OP_NOTE_ON, 42, 85);
    queue_event(OP_NOTE_OFF, 85, 1);
    queue_event(OP_NOTE_OFF, 42, 0);
    queue_event(OP_NOTE_ON, 127, 0);
    queue_event(OP_NOTE_ON, 127, 0);
    queue_event(OP_NOTE_ON, 1, 126);
    queue_event(OP_NOTE_OFF, 1, 127);

    // A full keyboard: every note pressed in random order, so the stack reaches
    // its whole depth, then released in random order.
    for (int n = 0; n < KEY_SPAN; n++) begin
      k = $urandom_range(0, KEY_SPAN - 1);
      while (gen_down[key_t'(k)]) k = (k + 1) % KEY_SPAN;
      queue_event(OP_NOTE_ON, k, $urandom_range(1, 127));
    end
    while (gen_held > 0) begin
      if ($urandom_range(0, 2) == 0 && gen_down[key_t'(gen_last)]) queue_release(gen_last);
      else queue_release(pick_held());
    end

    // Random part, mostly short phrases played on a few neighboring keys so that
    // presses, re-presses and releases of the sounding key interleave; some chords,
    // and some noise that includes releases of keys that are not down.
    while (key_events.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          queue_event(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                      $urandom_range(0, 127));
        end
      end else if (r < 20) begin
        len = $urandom_range(6, 30);
        repeat (len) queue_event(OP_NOTE_ON, $urandom_range(0, 127), $urandom_range(1, 127));
      end else begin
        base = $urandom_range(0, KEY_SPAN - 8);
        len  = $urandom_range(4, 24);
        repeat (len) begin
          if (gen_held > 0 && $urandom_range(0, 99) < (gen_held > 24 ? 75 : 40)) begin
            if ($urandom_range(0, 1) && gen_down[key_t'(gen_last)]) queue_release(gen_last);
            else queue_release(pick_held());
          end else begin
            queue_event(OP_NOTE_ON, base + $urandom_range(0, 7), $urandom_range(1, 127));
          end
        end
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (key_events.size() == 0 && !start && voice_due.size() == 0);
    // Keep the clock running so that any stray result beat shows up.
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Played %0d key events and checked %0d voice results; the stack reached %0d keys.",
             beats_played, results_seen, peak_held);
    $display("Expected commands: %0d attack, %0d release, %0d no change.",
             attack_count, release_count, quiet_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/lnpks_pkg.sv
sv/lnpks_cell.sv
sv/last_note_priority_key_stack.sv
tb/last_note_priority_key_stack_tb.sv
